// ===== sv/lcdnum_pkg.sv =====
// shared constants, codes and types of the lcd number display sequencer
`default_nettype none

package lcdnum_pkg;

  // sizing of the number path
  localparam int MAX_DIGITS   = 16;
  localparam int NUMBER_WIDTH = 16;
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_CNT_W    = $clog2(NUMBER_WIDTH + 1);
  // decimal digits of the widest value: floor(w * log10(2)) + 1
  localparam int BCD_DIGITS   = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W        = 4 * BCD_DIGITS;

  // request kinds
  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_SDEC = 3'd2;
  localparam logic [2:0] KIND_HEX  = 3'd3;
  localparam logic [2:0] KIND_BIN  = 3'd4;

  // bus byte constants
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] ROW2_OFFSET  = 8'h40;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_PLUS   = 8'h2B;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;

  // which write the datapath places on the bus
  localparam logic [2:0] SEL_NONE  = 3'd0;
  localparam logic [2:0] SEL_CMD   = 3'd1;
  localparam logic [2:0] SEL_CHAR  = 3'd2;
  localparam logic [2:0] SEL_SIGN  = 3'd3;
  localparam logic [2:0] SEL_DIGIT = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       conv_step;
    logic [2:0] sel;
    logic       last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       count_zero;
    logic       idx_zero;
    logic       conv_last;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/lcdnum_dp.sv =====
// datapath: request registers, binary to bcd converter, digit select and output registers
`default_nettype none

module lcdnum_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lcdnum_pkg::cmd_t            cmd,
  output lcdnum_pkg::status_t              status,
  input  wire logic [2:0]                  in_kind,
  input  wire logic [1:0]                  in_line,
  input  wire logic [5:0]                  in_column,
  input  wire logic [15:0]                 in_number,
  input  wire logic [4:0]                  in_digit_count,
  output logic                             out_valid,
  output logic                             out_is_data,
  output logic [7:0]                       out_bus_byte,
  output logic                             out_last
);
  import lcdnum_pkg::*;

  localparam int WIDE_W = 4 * MAX_DIGITS + NUMBER_WIDTH + BCD_W;

  logic [2:0]              kind_r;
  logic [7:0]              addr_r;
  logic [7:0]              char_r;
  logic                    neg_r;
  logic [NUMBER_WIDTH-1:0] mag_r;
  logic [NUMBER_WIDTH-1:0] bin_r;
  logic [BCD_W-1:0]        bcd_r;
  logic [BIT_CNT_W-1:0]    bit_cnt_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    out_valid_r;
  logic                    out_is_data_r;
  logic [7:0]              out_bus_byte_r;
  logic                    out_last_r;

  logic [NUMBER_WIDTH-1:0] value;
  logic                    neg;
  logic [NUMBER_WIDTH-1:0] mag;
  logic [7:0]              addr;
  logic [CNT_W-1:0]        count_sat;
  logic [BCD_W-1:0]        bcd_adj;
  logic [WIDE_W-1:0]       mag_wide;
  logic [WIDE_W-1:0]       bcd_wide;
  logic [3:0]              dig [MAX_DIGITS];
  logic [3:0]              cur_dig;
  logic [7:0]              dig_char;

  // request decode: value within the number width, sign and magnitude
  assign value = NUMBER_WIDTH'({{32{1'b0}}, in_number});
  assign neg   = (in_kind == KIND_SDEC) && value[NUMBER_WIDTH-1];
  assign mag   = neg ? (~value + NUMBER_WIDTH'(1)) : value;
  assign addr  = SET_ADDR_CMD | (8'(in_column) + 8'hFF +
                 ((in_line == 2'd1) ? 8'h00 : ROW2_OFFSET));
  assign count_sat = (int'(in_digit_count) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS)
                                                         : CNT_W'(in_digit_count);

  // add-3 adjust of every bcd column
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  // request registers and converter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      addr_r    <= addr;
      char_r    <= in_number[7:0];
      neg_r     <= neg;
      mag_r     <= mag;
      bin_r     <= mag;
      bcd_r     <= '0;
      bit_cnt_r <= BIT_CNT_W'(NUMBER_WIDTH);
      count_r   <= count_sat;
      idx_r     <= IDX_W'(count_sat - CNT_W'(1));
    end else begin
      if (cmd.conv_step) begin
        bcd_r     <= {bcd_adj[BCD_W-2:0], bin_r[NUMBER_WIDTH-1]};
        bin_r     <= bin_r << 1;
        bit_cnt_r <= bit_cnt_r - BIT_CNT_W'(1);
      end
      if (cmd.sel == SEL_DIGIT) begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end
  end

  // digit of every position, zero beyond the value
  assign mag_wide = WIDE_W'(mag_r);
  assign bcd_wide = WIDE_W'(bcd_r);

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      case (kind_r)
        KIND_HEX: dig[i] = mag_wide[4*i +: 4];
        KIND_BIN: dig[i] = {3'b000, mag_wide[i]};
        default:  dig[i] = bcd_wide[4*i +: 4];
      endcase
    end
  end

  assign cur_dig  = dig[idx_r];
  assign dig_char = (cur_dig < 4'd10) ? (ASCII_ZERO + 8'(cur_dig))
                                      : (ASCII_UPPER_A + 8'(cur_dig) - 8'd10);

  // output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.sel != SEL_NONE);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_last_r <= cmd.last;
    case (cmd.sel)
      SEL_CMD: begin
        out_is_data_r  <= 1'b0;
        out_bus_byte_r <= addr_r;
      end
      SEL_CHAR: begin
        out_is_data_r  <= 1'b1;
        out_bus_byte_r <= char_r;
      end
      SEL_SIGN: begin
        out_is_data_r  <= 1'b1;
        out_bus_byte_r <= neg_r ? ASCII_MINUS : ASCII_PLUS;
      end
      SEL_DIGIT: begin
        out_is_data_r  <= 1'b1;
        out_bus_byte_r <= dig_char;
      end
      default: begin
        out_is_data_r  <= out_is_data_r;
        out_bus_byte_r <= out_bus_byte_r;
      end
    endcase
  end

  assign status.kind       = kind_r;
  assign status.count_zero = (count_r == '0);
  assign status.idx_zero   = (idx_r == '0);
  assign status.conv_last  = (bit_cnt_r == BIT_CNT_W'(1));

  assign out_valid    = out_valid_r;
  assign out_is_data  = out_is_data_r;
  assign out_bus_byte = out_bus_byte_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// ===== sv/lcdnum_ctrl.sv =====
// controller: sequences conversion and the run of bus writes of one request
`default_nettype none

module lcdnum_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [2:0]          in_kind,
  input  wire lcdnum_pkg::status_t status,
  output lcdnum_pkg::cmd_t         cmd,
  output logic                     busy
);
  import lcdnum_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_CMD   = 3'd2;
  localparam logic [2:0] ST_CHAR  = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_DIGIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.sel       = SEL_NONE;
    cmd.last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_kind <= KIND_BIN)) begin
          cmd.load = 1'b1;
          if ((in_kind == KIND_UDEC) || (in_kind == KIND_SDEC)) begin
            state_nxt = ST_CONV;
          end else begin
            state_nxt = ST_CMD;
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        cmd.sel = SEL_CMD;
        if (status.kind == KIND_CHAR) begin
          state_nxt = ST_CHAR;
        end else if (status.kind == KIND_SDEC) begin
          state_nxt = ST_SIGN;
        end else if (status.count_zero) begin
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_CHAR: begin
        cmd.sel   = SEL_CHAR;
        cmd.last  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SIGN: begin
        cmd.sel = SEL_SIGN;
        if (status.count_zero) begin
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd.sel = SEL_DIGIT;
        if (status.idx_zero) begin
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/lcd_number_to_char_writes.sv =====
// top level of the character-lcd number display write sequencer
//
// a request is taken at a rising edge with start high and busy low; it carries
// in_kind, in_line, in_column, in_number and in_digit_count. kinds 5 to 7 are
// dropped at once and produce no writes.
// each bus write appears on out_is_data, out_bus_byte and out_last for one
// cycle with out_valid high; out_last marks the final write of the request.
// the run is the set-address command, then the char byte, or the sign in
// signed mode and then the digits, most significant first.
// decimal kinds first run a shift-and-add-3 converter over all NUMBER_WIDTH
// bits of the value. the first write then passes the state register and the
// output registers; after it comes one write per cycle. busy stays high
// until the last write is on the ports; it comes from the write sequencer
// state machine.
// the receiver cannot stall; every write is taken in its cycle.
// reset (synchronous, active low) returns the controller to idle and clears
// out_valid.
`default_nettype none

module lcd_number_to_char_writes (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [1:0]  in_line,
  input  wire logic [5:0]  in_column,
  input  wire logic [15:0] in_number,
  input  wire logic [4:0]  in_digit_count,
  output logic             out_valid,
  output logic             out_is_data,
  output logic [7:0]       out_bus_byte,
  output logic             out_last
);
  import lcdnum_pkg::*;

  cmd_t    cmd;
  status_t status;

  // write sequencer
  lcdnum_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // number path and output registers
  lcdnum_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (in_kind),
    .in_line        (in_line),
    .in_column      (in_column),
    .in_number      (in_number),
    .in_digit_count (in_digit_count),
    .out_valid      (out_valid),
    .out_is_data    (out_is_data),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
